/* rtl/bsfr_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the frame receiver.
package bsfr_pkg;

  localparam int FRAME_LEN = 8;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int IDX_W     = 3;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] ESC_BYTE   = 8'hDA;
  localparam logic [7:0] ESC_START  = 8'hDB;
  localparam logic [7:0] ESC_ESC    = 8'hDC;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_FRAME,
    ST_ESC,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_ZERO,
    POS_ONE,
    POS_INC
  } pos_op_t;

  typedef enum logic [1:0] {
    WR_RAW,
    WR_START,
    WR_ESC
  } wr_sel_t;

  typedef struct packed {
    logic    wr_en;
    pos_op_t pos_op;
    wr_sel_t wr_sel;
    logic    drain_load;
    logic    drain_en;
  } cmd_t;

  typedef struct packed {
    logic at_last;
    logic start_ok;
    logic is_start;
    logic is_esc;
    logic is_esc_start;
    logic is_esc_esc;
    logic rd_last_issue;
  } status_t;

endpackage

/* rtl/byte_stuffed_frame_receiver.sv */
// Byte-stuffed fixed-length frame receiver: top level joining controller and datapath.
//
// Takes one received serial word per cycle while hunting or inside a frame, decodes
// the 0xDA escape pairs, and stores the frame in a FRAME_LEN-entry frame store. When
// the word at the last position arrives and position 0 holds the sync word, the
// FRAME_LEN-1 payload words are read out of the store one per cycle while the output
// register is free or not stalled, through its registered read port, in order, each
// with its payload index and a last flag on the final one. During that drain the input
// is stalled; words that do not complete a frame give no output. Input is taken again
// as soon as the last read is issued, while that word still waits in the output
// register. The frame store needs no clearing.
module byte_stuffed_frame_receiver (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_payload_byte,
  output logic [bsfr_pkg::IDX_W-1:0] out_payload_index,
  output logic                       out_frame_last
);
  import bsfr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Parse and drain sequencing
  bsfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Frame storage and output word
  bsfr_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .status            (status),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_last    (out_frame_last)
  );

endmodule

/* rtl/bsfr_ctrl.sv */
// Parse and drain controller of the frame receiver.
module bsfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsfr_pkg::status_t status,
  output bsfr_pkg::cmd_t    cmd
);
  import bsfr_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // Hold off input words while the frame store drains
  assign in_stall = (state_r == ST_DRAIN);
  assign accept   = in_valid && !in_stall;

  // Advance state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (accept) begin
          if (status.at_last) begin
            state_nxt = status.start_ok ? ST_DRAIN : ST_HUNT;
          end else if (status.is_start) begin
            state_nxt = ST_FRAME;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_FRAME: begin
        if (accept) begin
          if (status.at_last) begin
            state_nxt = status.start_ok ? ST_DRAIN : ST_HUNT;
          end else if (status.is_esc) begin
            state_nxt = ST_ESC;
          end
        end
      end
      ST_ESC: begin
        if (accept) begin
          if (status.at_last) begin
            state_nxt = status.start_ok ? ST_DRAIN : ST_HUNT;
          end else if (status.is_esc_start || status.is_esc_esc || status.is_start) begin
            state_nxt = ST_FRAME;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_DRAIN: begin
        if (status.rd_last_issue) begin
          state_nxt = ST_HUNT;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd            = '0;
    cmd.pos_op     = POS_HOLD;
    cmd.wr_sel     = WR_RAW;
    cmd.wr_en      = accept;
    cmd.drain_en   = (state_r == ST_DRAIN);
    if (accept) begin
      if (status.at_last) begin
        cmd.pos_op     = POS_ZERO;
        cmd.drain_load = status.start_ok;
      end else begin
        case (state_r)
          ST_FRAME: begin
            if (status.is_esc) begin
              cmd.pos_op = POS_HOLD;
            end else if (status.is_start) begin
              cmd.pos_op = POS_ONE;
            end else begin
              cmd.pos_op = POS_INC;
            end
          end
          ST_ESC: begin
            if (status.is_esc_start) begin
              cmd.wr_sel = WR_START;
              cmd.pos_op = POS_INC;
            end else if (status.is_esc_esc) begin
              cmd.wr_sel = WR_ESC;
              cmd.pos_op = POS_INC;
            end else if (status.is_start) begin
              cmd.pos_op = POS_ONE;
            end else begin
              cmd.pos_op = POS_ZERO;
            end
          end
          default: begin
            cmd.pos_op = status.is_start ? POS_ONE : POS_ZERO;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/bsfr_datapath.sv */
// Frame store, write position, drain pointer and output register of the frame receiver.
module bsfr_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [7:0]                   in_rx_byte,
  input  bsfr_pkg::cmd_t               cmd,
  output bsfr_pkg::status_t            status,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [7:0]                   out_payload_byte,
  output logic [bsfr_pkg::IDX_W-1:0]   out_payload_index,
  output logic                         out_frame_last
);
  import bsfr_pkg::*;

  logic [7:0]       store_r [FRAME_LEN];
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] rd_ptr_r;
  logic [POS_W-1:0] rd_ptr_nxt;
  logic [POS_W-1:0] rd_k;
  logic             start_ok_r;
  logic [7:0]       wdata;
  logic             adv;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_last_r;

  // Classify the incoming word
  always_comb begin
    status               = '0;
    status.at_last       = (pos_r == LAST_POS);
    status.start_ok      = start_ok_r;
    status.is_start      = (in_rx_byte == SYNC_BYTE);
    status.is_esc        = (in_rx_byte == ESC_BYTE);
    status.is_esc_start  = (in_rx_byte == ESC_START);
    status.is_esc_esc    = (in_rx_byte == ESC_ESC);
    status.rd_last_issue = adv && (rd_ptr_r == LAST_POS);
  end

  // Select the stored value: raw or decoded escape
  always_comb begin
    case (cmd.wr_sel)
      WR_START: wdata = SYNC_BYTE;
      WR_ESC:   wdata = ESC_BYTE;
      default:  wdata = in_rx_byte;
    endcase
  end

  // Next write position
  always_comb begin
    case (cmd.pos_op)
      POS_ZERO: pos_nxt = '0;
      POS_ONE:  pos_nxt = POS_W'(1);
      POS_INC:  pos_nxt = pos_r + POS_W'(1);
      default:  pos_nxt = pos_r;
    endcase
  end

  // Issue one store read per free output slot while draining
  assign adv        = cmd.drain_en && (!out_valid_r || !out_stall);
  assign rd_ptr_nxt = rd_ptr_r + POS_W'(1);
  assign rd_k       = rd_ptr_r - POS_W'(1);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rd_ptr_r    <= POS_W'(1);
      start_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        pos_r <= pos_nxt;
        if (pos_r == '0) begin
          start_ok_r <= (wdata == SYNC_BYTE);
        end
      end
      if (cmd.drain_load) begin
        rd_ptr_r <= POS_W'(1);
      end else if (adv) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frame store write and registered read into the output word
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      store_r[pos_r] <= wdata;
    end
    if (adv) begin
      out_byte_r  <= store_r[rd_ptr_r];
      out_index_r <= IDX_W'(rd_k);
      out_last_r  <= (rd_ptr_r == LAST_POS);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_byte_r;
  assign out_payload_index = out_index_r;
  assign out_frame_last    = out_last_r;

`ifndef SYNTHESIS
  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_en |-> !cmd.wr_en)
    else $error("frame store written while draining");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("write position beyond frame");

  a_last_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (rd_ptr_r == LAST_POS)) |=> (out_valid_r && out_last_r))
    else $error("final payload word not flagged");

  a_drain_from_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_load |=> (rd_ptr_r == POS_W'(1)))
    else $error("drain pointer not restarted");
`endif

endmodule

/* sim/tb_byte_stuffed_frame_receiver.sv */
// Self-checking testbench for the byte-stuffed frame receiver with its own frame decoder.
`timescale 1ns / 100ps

module tb_byte_stuffed_frame_receiver;
  import bsfr_pkg::*;

  typedef struct {
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } payload_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_payload_byte;
  logic [IDX_W-1:0] out_payload_index;
  logic             out_frame_last;

  // Decoder state mirrored from the block
  logic [7:0]       frame_mem [FRAME_LEN];
  logic [POS_W-1:0] wr_pos = '0;
  state_t           parse_st = ST_HUNT;
  payload_t         payload_q [$];

  int  err_count = 0;
  int  word_count = 0;
  bit  idle_on = 1'b1;

  byte_stuffed_frame_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_last    (out_frame_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Advance the decoder by one received word and queue any payload it completes
  task automatic decode_rx_word(input logic [7:0] b);
    logic [POS_W-1:0] p;
    payload_t         pl;
    p = wr_pos;
    if (int'(p) >= FRAME_LEN) begin
      p = '0;
    end
    frame_mem[p] = b;
    if (p == LAST_POS) begin
      // Last position: store raw and emit the whole payload if position 0 holds the sync word
      if (frame_mem[0] == SYNC_BYTE) begin
        for (int i = 1; i < FRAME_LEN; i++) begin
          pl.data = frame_mem[i];
          pl.idx  = IDX_W'(i - 1);
          pl.last = (i == FRAME_LEN - 1);
          payload_q.push_back(pl);
        end
      end
      wr_pos   = '0;
      parse_st = ST_HUNT;
    end else begin
      case (parse_st)
        ST_FRAME: begin
          if (b == ESC_BYTE) begin
            parse_st = ST_ESC;
          end else if (b == SYNC_BYTE) begin
            p = POS_W'(1);
          end else begin
            p = p + POS_W'(1);
          end
        end
        ST_ESC: begin
          if (b == ESC_START) begin
            frame_mem[p] = SYNC_BYTE;
            p = p + POS_W'(1);
            parse_st = ST_FRAME;
          end else if (b == ESC_ESC) begin
            frame_mem[p] = ESC_BYTE;
            p = p + POS_W'(1);
            parse_st = ST_FRAME;
          end else if (b == SYNC_BYTE) begin
            p = POS_W'(1);
            parse_st = ST_FRAME;
          end else begin
            // Bad escape code: drop the frame
            p = '0;
            parse_st = ST_HUNT;
          end
        end
        default: begin
          if (b == SYNC_BYTE) begin
            p = POS_W'(1);
            parse_st = ST_FRAME;
          end else begin
            p = '0;
            parse_st = ST_HUNT;
          end
        end
      endcase
      wr_pos = p;
    end
  endtask

  // Offer one word, with an optional idle burst ahead of it, and hold until taken
  task automatic send_word(input logic [7:0] b);
    bit taken;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (!in_stall) begin
        taken = 1'b1;
        decode_rx_word(b);
        word_count++;
      end
      @(posedge clk);
    end
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) begin
      send_word(seq[i]);
    end
  endtask

  // Drop valid and hold until every queued payload word has drained
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (payload_q.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Random byte, biased toward the framing codes and the extremes
  function automatic logic [7:0] pick_byte();
    logic [7:0] specials [6];
    specials = '{SYNC_BYTE, ESC_BYTE, ESC_START, ESC_ESC, 8'h00, 8'hFF};
    if ($urandom_range(0, 3) == 0) begin
      return specials[$urandom_range(0, 5)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly a well-formed stuffed frame; now and then a break inside it
  task automatic send_random_frame();
    int         kind;
    logic [7:0] b;
    send_word(SYNC_BYTE);
    for (int p = 1; p < FRAME_LEN - 1; p++) begin
      kind = $urandom_range(0, 39);
      if (kind == 0) begin
        send_word(SYNC_BYTE);
      end else if (kind == 1) begin
        b = 8'($urandom_range(0, 255));
        while (b == ESC_START || b == ESC_ESC || b == SYNC_BYTE) begin
          b = 8'($urandom_range(0, 255));
        end
        send_word(ESC_BYTE);
        send_word(b);
        return;
      end else if (kind == 2) begin
        send_word(ESC_BYTE);
        send_word(SYNC_BYTE);
      end else begin
        b = pick_byte();
        if (b == SYNC_BYTE) begin
          send_word(ESC_BYTE);
          send_word(ESC_START);
        end else if (b == ESC_BYTE) begin
          send_word(ESC_BYTE);
          send_word(ESC_ESC);
        end else begin
          send_word(b);
        end
      end
    end
    // Last position goes in raw
    send_word(pick_byte());
  endtask

  task automatic send_random_traffic(input int n_words);
    int first;
    first = word_count;
    while (word_count - first < n_words) begin
      if ($urandom_range(0, 9) < 8) begin
        send_random_frame();
      end else begin
        repeat ($urandom_range(1, 3)) send_word(pick_byte());
      end
    end
  endtask

  task automatic test_escaped_frame();
    send_bytes('{SYNC_BYTE, 8'h00, 8'hFF, ESC_BYTE, ESC_START, ESC_BYTE, ESC_ESC,
                 8'h80, 8'h7F, ESC_BYTE});
  endtask

  task automatic test_noise_and_bad_escape();
    send_bytes('{ESC_BYTE, SYNC_BYTE, 8'h11, ESC_BYTE, 8'h22});
  endtask

  task automatic test_resync();
    send_bytes('{SYNC_BYTE, 8'h33, SYNC_BYTE, ESC_BYTE, SYNC_BYTE, 8'h01, 8'h02,
                 8'h03, 8'h04, 8'h05, 8'h06, SYNC_BYTE});
  endtask

  task automatic test_random_traffic();
    send_random_traffic(100);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    send_random_traffic(90);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    send_random_traffic(50);
  endtask

  // Stall the result channel in random bursts while idle_on is set
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Sample each taken payload word mid-cycle, compare at its handshake edge
  initial begin
    payload_t   want;
    logic [7:0] got_data;
    logic [IDX_W-1:0] got_idx;
    logic       got_last;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got_data = out_payload_byte;
        got_idx  = out_payload_index;
        got_last = out_frame_last;
        @(posedge clk);
        if (payload_q.size() == 0) begin
          report_mismatch($sformatf("unexpected payload word %02h idx %0d", got_data,
                                    got_idx));
        end else begin
          want = payload_q.pop_front();
          if (got_data !== want.data) begin
            report_mismatch($sformatf("payload_byte %02h, want %02h", got_data,
                                      want.data));
          end
          if (got_idx !== want.idx) begin
            report_mismatch($sformatf("payload_index %0d, want %0d", got_idx, want.idx));
          end
          if (got_last !== want.last) begin
            report_mismatch($sformatf("frame_last %0b, want %0b", got_last, want.last));
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escaped_frame();
    test_noise_and_bad_escape();
    test_resync();
    test_random_traffic();
    test_drain_pause();
    test_back_to_back();
    wait_drained();
    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
